// ===== src/cbpe_pkg.sv =====
`default_nettype none
package cbpe_pkg;

	// sweep length and the widths that follow from it
	localparam int STEPS     = 2048;
	localparam int IDX_W     = 11;
	localparam int J_W       = IDX_W + 1;
	localparam int SQ_I_W    = 2 * IDX_W;
	localparam int SQ_J_W    = 2 * J_W;
	localparam int FRAC_W    = 3 * IDX_W;
	localparam int W_W       = FRAC_W + 1;
	localparam int COORD_W   = 16;
	localparam int PROD_W    = W_W + 1 + COORD_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CTRL  = 8;
	localparam int NUM_TERMS = 4;

	typedef logic        [IDX_W-1:0]     step_t;
	typedef logic signed [COORD_W-1:0]   coord_t;
	typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic        [W_W-1:0]       weight_t;

	// register map of the control points
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X0 = 3'd0,
		REG_Y0 = 3'd1,
		REG_X1 = 3'd2,
		REG_Y1 = 3'd3,
		REG_X2 = 3'd4,
		REG_Y2 = 3'd5,
		REG_X3 = 3'd6,
		REG_Y3 = 3'd7
	} ctrl_reg_t;

endpackage
`default_nettype wire

// ===== src/cbpe_in_if.sv =====
`default_nettype none
interface cbpe_in_if;
	logic                 valid;
	logic                 ready;
	cbpe_pkg::step_t      step_index;

	modport source (output valid, output step_index, input ready);
	modport sink   (input valid, input step_index, output ready);
endinterface
`default_nettype wire

// ===== src/cbpe_out_if.sv =====
`default_nettype none
interface cbpe_out_if;
	logic                 valid;
	logic                 ready;
	cbpe_pkg::coord_t     point_x;
	cbpe_pkg::coord_t     point_y;
	logic                 last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink   (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface
`default_nettype wire

// ===== src/cbpe_cfg_if.sv =====
`default_nettype none
interface cbpe_cfg_if;
	logic                 valid;
	logic                 ready;
	cbpe_pkg::cfg_idx_t   index;
	cbpe_pkg::coord_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/cubic_bezier_point_eval.sv =====
`default_nettype none
// cubic bezier point evaluator
// cfg: write words of (index, data) load the four control points, index 0..7 in the
//   order x0 y0 x1 y1 x2 y2 x3 y3; cfg is always ready; write only while the block is idle
// step: each word carries a step index i; the curve is evaluated at t = i / 2048
// point: one word per step word, x and y truncated toward zero, last_point set on
//   the final step of the sweep (i = 2047)
// path: an accepted step word is registered in s1 through s6 in turn, and s6 drives point
// throughput: one word per cycle while point is not stalled, set by the six-stage pipeline
//   s1 i, j = 2048 - i and their squares
//   s2 cubes and the two mixed products
//   s3 times three for the middle Bernstein weights
//   s4 eight 35x16 weight by coordinate products
//   s5 four-term sums per axis
//   s6 truncating shift by 33 bits (the output register)
// each stage holds while the one after it is full and stalled, so a stalled receiver
// fills the bubbles first and only then drops step.ready; nothing is lost or repeated
// reset clears the control points to zero and empties the pipeline
module cubic_bezier_point_eval (
	input  wire        clk,
	input  wire        arst_n,
	cbpe_in_if.sink    step,
	cbpe_out_if.source point,
	cbpe_cfg_if.sink   cfg
);

	localparam logic [cbpe_pkg::ACC_W-1:0] BIAS =
		(cbpe_pkg::ACC_W'(1) << cbpe_pkg::FRAC_W) - cbpe_pkg::ACC_W'(1);

	// control point registers
	cbpe_pkg::coord_t ctrl_q [cbpe_pkg::NUM_CTRL];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cbpe_pkg::NUM_CTRL; k++) begin
				ctrl_q[k] <= '0;
			end
		end else if (cfg.valid) begin
			ctrl_q[cfg.index] <= cfg.data;
		end
	end

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || point.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign step.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= step.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// s1: i, j and squares; an 11-bit index never exceeds the last step
	logic [cbpe_pkg::J_W-1:0]    j_c;
	cbpe_pkg::step_t             i_s1;
	logic [cbpe_pkg::J_W-1:0]    j_s1;
	logic [cbpe_pkg::SQ_I_W-1:0] ii_s1;
	logic [cbpe_pkg::SQ_J_W-1:0] jj_s1;
	logic                        last_s1;

	assign j_c = cbpe_pkg::J_W'(cbpe_pkg::STEPS) - {1'b0, step.step_index};

	always_ff @(posedge clk) begin
		if (en1 && step.valid) begin
			i_s1    <= step.step_index;
			j_s1    <= j_c;
			ii_s1   <= cbpe_pkg::SQ_I_W'(step.step_index) * cbpe_pkg::SQ_I_W'(step.step_index);
			jj_s1   <= cbpe_pkg::SQ_J_W'(j_c) * cbpe_pkg::SQ_J_W'(j_c);
			last_s1 <= (step.step_index == cbpe_pkg::IDX_W'(cbpe_pkg::STEPS - 1));
		end
	end

	// s2: j^3, i^3, i*j^2, i^2*j
	cbpe_pkg::weight_t w0_s2, w3_s2, t1_s2, t2_s2;
	logic              last_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			w0_s2   <= cbpe_pkg::W_W'(jj_s1) * cbpe_pkg::W_W'(j_s1);
			w3_s2   <= cbpe_pkg::W_W'(ii_s1) * cbpe_pkg::W_W'(i_s1);
			t1_s2   <= cbpe_pkg::W_W'(jj_s1) * cbpe_pkg::W_W'(i_s1);
			t2_s2   <= cbpe_pkg::W_W'(ii_s1) * cbpe_pkg::W_W'(j_s1);
			last_s2 <= last_s1;
		end
	end

	// s3: Bernstein weights scaled by 2^33
	cbpe_pkg::weight_t w_s3 [cbpe_pkg::NUM_TERMS];
	logic              last_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			w_s3[0] <= w0_s2;
			w_s3[1] <= t1_s2 + (t1_s2 << 1);
			w_s3[2] <= t2_s2 + (t2_s2 << 1);
			w_s3[3] <= w3_s2;
			last_s3 <= last_s2;
		end
	end

	// s4: weight times coordinate
	logic signed [cbpe_pkg::PROD_W-1:0] px_s4 [cbpe_pkg::NUM_TERMS];
	logic signed [cbpe_pkg::PROD_W-1:0] py_s4 [cbpe_pkg::NUM_TERMS];
	logic                               last_s4;
	logic signed [cbpe_pkg::W_W:0]      ws_c  [cbpe_pkg::NUM_TERMS];

	always_comb begin
		for (int k = 0; k < cbpe_pkg::NUM_TERMS; k++) begin
			ws_c[k] = $signed({1'b0, w_s3[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int k = 0; k < cbpe_pkg::NUM_TERMS; k++) begin
				px_s4[k] <= ws_c[k] * ctrl_q[2*k];
				py_s4[k] <= ws_c[k] * ctrl_q[2*k+1];
			end
			last_s4 <= last_s3;
		end
	end

	// s5: weighted sums
	logic signed [cbpe_pkg::ACC_W-1:0] accx_s5, accy_s5;
	logic                              last_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			accx_s5 <= cbpe_pkg::ACC_W'(px_s4[0]) + cbpe_pkg::ACC_W'(px_s4[1])
				+ cbpe_pkg::ACC_W'(px_s4[2]) + cbpe_pkg::ACC_W'(px_s4[3]);
			accy_s5 <= cbpe_pkg::ACC_W'(py_s4[0]) + cbpe_pkg::ACC_W'(py_s4[1])
				+ cbpe_pkg::ACC_W'(py_s4[2]) + cbpe_pkg::ACC_W'(py_s4[3]);
			last_s5 <= last_s4;
		end
	end

	// s6: divide by 2^33 toward zero, bias negative sums before the shift
	logic [cbpe_pkg::ACC_W-1:0] adjx_c, adjy_c;
	cbpe_pkg::coord_t           px_s6, py_s6;
	logic                       last_s6;

	assign adjx_c = accx_s5 + (accx_s5[cbpe_pkg::ACC_W-1] ? BIAS : '0);
	assign adjy_c = accy_s5 + (accy_s5[cbpe_pkg::ACC_W-1] ? BIAS : '0);

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			px_s6   <= adjx_c[cbpe_pkg::FRAC_W +: cbpe_pkg::COORD_W];
			py_s6   <= adjy_c[cbpe_pkg::FRAC_W +: cbpe_pkg::COORD_W];
			last_s6 <= last_s5;
		end
	end

	assign point.valid      = v_s6;
	assign point.point_x    = px_s6;
	assign point.point_y    = py_s6;
	assign point.last_point = last_s6;

endmodule
`default_nettype wire
